// ===== hdl/dpr_pkg.sv =====
// Shared types and constants for the disparity-to-point reprojection block.
// No dependencies.
package dpr_pkg;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_BASELINE = 3'd4
  } cfg_reg_t;

  localparam int FOCAL_FRAC  = 8;
  localparam int CENTER_FRAC = 4;
  localparam int BASE_W      = 20;
  localparam int QUO_W       = 33;

  localparam int FOCAL_X_RST  = 256000;
  localparam int FOCAL_Y_RST  = 256000;
  localparam int CENTER_X_RST = 10240;
  localparam int CENTER_Y_RST = 5760;
  localparam int BASELINE_RST = 100000;

  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic       dr_zero;
    logic       fy_zero;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } side_t;

endpackage

// ===== hdl/dpr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Standalone; used by disparity_to_point_reprojection.
module dpr_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 24,
  parameter int Q_W   = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic [Q_W-1:0]   out_q,
  output logic             out_ovf
);

  localparam int EXT_W = NUM_W + DEN_W;

  logic [EXT_W-1:0] hi_ext;
  logic             ovf_nxt;

  logic [DEN_W-1:0] rem_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   lo_r  [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];
  logic             ovf_r [0:Q_W];

  assign hi_ext  = {{DEN_W{1'b0}}, in_num} >> Q_W;
  assign ovf_nxt = hi_ext >= {{NUM_W{1'b0}}, in_den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[DEN_W-1:0];
      den_r[0] <= in_den;
      lo_r[0]  <= in_num[Q_W-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_nxt;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;

    assign trial   = {rem_r[j], lo_r[j][Q_W-1]};
    assign diff    = trial - {1'b0, den_r[j]};
    assign ge      = trial >= {1'b0, den_r[j]};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= rem_nxt;
        den_r[j+1] <= den_r[j];
        lo_r[j+1]  <= lo_r[j] << 1;
        q_r[j+1]   <= {q_r[j][Q_W-2:0], ge};
        ovf_r[j+1] <= ovf_r[j];
      end
    end
  end

  assign out_q   = q_r[Q_W];
  assign out_ovf = ovf_r[Q_W];

endmodule

// ===== hdl/disparity_to_point_reprojection.sv =====
// Disparity to 3-D point reprojection, top level. Uses dpr_pkg and dpr_div.
// Pipeline of 4 front stages, 34 divider stages and the output register.
// Throughput: one item per cycle while the output is not stalled; the three
// dividers are fully pipelined at one quotient bit per stage.
// The whole pipeline holds while the output register is stalled.
// Synchronous active-low reset clears valid bits and loads register defaults.
module disparity_to_point_reprojection import dpr_pkg::*; #(
  parameter int COORD_BITS     = 12,
  parameter int DISP_FRAC_BITS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [((COORD_BITS+8 > 20) ? COORD_BITS+8 : 20)-1:0] cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [COORD_BITS-1:0]                  in_column,
  input  logic [COORD_BITS-1:0]                  in_row,
  input  logic signed [COORD_BITS+DISP_FRAC_BITS:0] in_disparity,
  input  logic                                   in_disparity_finite,
  input  logic [7:0]                             in_red,
  input  logic [7:0]                             in_green,
  input  logic [7:0]                             in_blue,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [31:0]                     out_point_x,
  output logic signed [31:0]                     out_point_y,
  output logic [31:0]                            out_point_depth,
  output logic [7:0]                             out_point_red,
  output logic [7:0]                             out_point_green,
  output logic [7:0]                             out_point_blue
);

  localparam int FW      = COORD_BITS + FOCAL_FRAC;
  localparam int CW      = COORD_BITS + CENTER_FRAC;
  localparam int BW      = BASE_W;
  localparam int DISP_W  = COORD_BITS + DISP_FRAC_BITS + 1;
  localparam int DW      = COORD_BITS + DISP_FRAC_BITS;
  localparam int FXB_W   = FW + BW;
  localparam int H       = FXB_W / 2;
  localparam int DCB_W   = CW + BW;
  localparam int FYD_W   = FW + DW;
  localparam int PLO_W   = CW + H;
  localparam int PHI_W   = CW + FXB_W - H;
  localparam int NDW     = FXB_W + DISP_FRAC_BITS + 1;
  localparam int DDW     = DW + FOCAL_FRAC;
  localparam int NXW     = DCB_W + DISP_FRAC_BITS + 1;
  localparam int DXW     = DW + CENTER_FRAC;
  localparam int NYW     = CW + FXB_W + DISP_FRAC_BITS + 1;
  localparam int DYW     = FYD_W + CENTER_FRAC;
  localparam int DIV_LAT = QUO_W + 1;

  // configuration
  logic [FW-1:0] fx_r, fy_r;
  logic [CW-1:0] cx_r, cy_r;
  logic [BW-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r   <= FW'(FOCAL_X_RST);
      fy_r   <= FW'(FOCAL_Y_RST);
      cx_r   <= CW'(CENTER_X_RST);
      cy_r   <= CW'(CENTER_Y_RST);
      base_r <= BW'(BASELINE_RST);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:  fx_r   <= cfg_wdata[FW-1:0];
        REG_FOCAL_Y:  fy_r   <= cfg_wdata[FW-1:0];
        REG_CENTER_X: cx_r   <= cfg_wdata[CW-1:0];
        REG_CENTER_Y: cy_r   <= cfg_wdata[CW-1:0];
        REG_BASELINE: base_r <= cfg_wdata[BW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 1: filter, offsets from the principal point
  logic          disp_pos, keep_nxt;
  logic [DW-1:0] dq_nxt, colsh;
  logic [CW:0]   dcx, dcy;
  side_t         side1_nxt;
  logic [CW-1:0] adc_nxt, adr_nxt;

  always_comb begin
    disp_pos = !in_disparity[DISP_W-1] && (in_disparity != '0);
    dq_nxt   = in_disparity[DW-1:0];
    colsh    = DW'(in_column) << DISP_FRAC_BITS;
    keep_nxt = in_disparity_finite && disp_pos && !(colsh < dq_nxt) &&
               (fx_r != '0) && (base_r != '0);
    dcx      = {1'b0, in_column, {CENTER_FRAC{1'b0}}} - {1'b0, cx_r};
    dcy      = {1'b0, in_row, {CENTER_FRAC{1'b0}}} - {1'b0, cy_r};
    adc_nxt  = dcx[CW] ? CW'(-dcx) : dcx[CW-1:0];
    adr_nxt  = dcy[CW] ? CW'(-dcy) : dcy[CW-1:0];
    side1_nxt.neg_x   = dcx[CW];
    side1_nxt.neg_y   = dcy[CW];
    side1_nxt.dr_zero = (dcy == '0);
    side1_nxt.fy_zero = (fy_r == '0);
    side1_nxt.red     = in_red;
    side1_nxt.green   = in_green;
    side1_nxt.blue    = in_blue;
  end

  logic          v1_r, v2_r, v3_r, v4_r;
  logic [DW-1:0] dq1_r, dq2_r, dq3_r;
  logic [CW-1:0] adc1_r, adr1_r, adr2_r;
  side_t         side1_r, side2_r, side3_r, side4_r;
  logic [FXB_W-1:0] fxb2_r, fxb3_r;
  logic [DCB_W-1:0] dcb2_r, dcb3_r;
  logic [FYD_W-1:0] fyd2_r, fyd3_r;
  logic [PLO_W-1:0] plo3_r;
  logic [PHI_W-1:0] phi3_r;
  logic [NDW-1:0]   numd4_r;
  logic [DDW-1:0]   dend4_r;
  logic [NXW-1:0]   numx4_r;
  logic [DXW-1:0]   denx4_r;
  logic [NYW-1:0]   numy4_r, prody_nxt;
  logic [DYW-1:0]   deny4_r;

  assign prody_nxt = (NYW'(phi3_r) << H) + NYW'(plo3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && keep_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq1_r   <= dq_nxt;
      adc1_r  <= adc_nxt;
      adr1_r  <= adr_nxt;
      side1_r <= side1_nxt;
      // stage 2
      fxb2_r  <= FXB_W'(fx_r) * FXB_W'(base_r);
      dcb2_r  <= DCB_W'(adc1_r) * DCB_W'(base_r);
      fyd2_r  <= FYD_W'(fy_r) * FYD_W'(dq1_r);
      dq2_r   <= dq1_r;
      adr2_r  <= adr1_r;
      side2_r <= side1_r;
      // stage 3
      plo3_r  <= PLO_W'(adr2_r) * PLO_W'(fxb2_r[H-1:0]);
      phi3_r  <= PHI_W'(adr2_r) * PHI_W'(fxb2_r[FXB_W-1:H]);
      fxb3_r  <= fxb2_r;
      dcb3_r  <= dcb2_r;
      fyd3_r  <= fyd2_r;
      dq3_r   <= dq2_r;
      side3_r <= side2_r;
      // stage 4: rounded numerators and denominators
      numd4_r <= (NDW'(fxb3_r) << DISP_FRAC_BITS) + (NDW'(dq3_r) << (FOCAL_FRAC - 1));
      dend4_r <= DDW'(dq3_r) << FOCAL_FRAC;
      numx4_r <= (NXW'(dcb3_r) << DISP_FRAC_BITS) + (NXW'(dq3_r) << (CENTER_FRAC - 1));
      denx4_r <= DXW'(dq3_r) << CENTER_FRAC;
      numy4_r <= (prody_nxt << DISP_FRAC_BITS) + (NYW'(fyd3_r) << (CENTER_FRAC - 1));
      deny4_r <= DYW'(fyd3_r) << CENTER_FRAC;
      side4_r <= side3_r;
    end
  end

  logic [QUO_W-1:0] qd, qx, qy;
  logic             ovd, ovx, ovy;

  dpr_div #(.NUM_W(NDW), .DEN_W(DDW), .Q_W(QUO_W)) u_div_depth (
    .clk(clk), .en(en), .in_num(numd4_r), .in_den(dend4_r), .out_q(qd), .out_ovf(ovd)
  );
  dpr_div #(.NUM_W(NXW), .DEN_W(DXW), .Q_W(QUO_W)) u_div_x (
    .clk(clk), .en(en), .in_num(numx4_r), .in_den(denx4_r), .out_q(qx), .out_ovf(ovx)
  );
  dpr_div #(.NUM_W(NYW), .DEN_W(DYW), .Q_W(QUO_W)) u_div_y (
    .clk(clk), .en(en), .in_num(numy4_r), .in_den(deny4_r), .out_q(qy), .out_ovf(ovy)
  );

  logic  vd_r   [0:DIV_LAT-1];
  side_t sided_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= v4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r[0] <= side4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sided_r[i] <= sided_r[i-1];
      end
    end
  end

  // output stage: saturation and sign
  side_t       so;
  logic        bigx, bigy;
  logic [31:0] x_nxt, y_nxt, d_nxt;

  always_comb begin
    so   = sided_r[DIV_LAT-1];
    bigx = ovx || qx[QUO_W-1] || qx[31];
    bigy = ovy || qy[QUO_W-1] || qy[31];
    if (ovd || qd[QUO_W-1]) begin
      d_nxt = 32'hFFFF_FFFF;
    end else if (qd[31:0] == '0) begin
      d_nxt = 32'd1;
    end else begin
      d_nxt = qd[31:0];
    end
    if (bigx) begin
      x_nxt = so.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      x_nxt = so.neg_x ? -qx[31:0] : qx[31:0];
    end
    if (so.fy_zero) begin
      if (so.dr_zero) begin
        y_nxt = '0;
      end else begin
        y_nxt = so.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end else if (bigy) begin
      y_nxt = so.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      y_nxt = so.neg_y ? -qy[31:0] : qy[31:0];
    end
  end

  logic [31:0] x_r, y_r, d_r;
  logic [7:0]  red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      d_r     <= d_nxt;
      red_r   <= so.red;
      green_r <= so.green;
      blue_r  <= so.blue;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = x_r;
  assign out_point_y     = y_r;
  assign out_point_depth = d_r;
  assign out_point_red   = red_r;
  assign out_point_green = green_r;
  assign out_point_blue  = blue_r;

endmodule
